@@ sv/ppbc_pkg.sv @@
// ----------------------------------------------------------------------------
// ppbc_pkg
// Shared widths, constants and types of the pump pressure band controller.
// ----------------------------------------------------------------------------
package ppbc_pkg;

  localparam int PRESS_W = 12;
  localparam int GAIN_W  = 8;
  localparam int DUTY_W  = 12;
  localparam int MODE_W  = 2;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  localparam logic [DUTY_W-1:0]  DUTY_MAX      = 12'd3999;
  localparam logic [DUTY_W-1:0]  RAISE_PRELOAD = 12'd1999;
  localparam logic [PRESS_W-1:0] SET_RESET     = 12'd976;
  localparam logic [GAIN_W-1:0]  GAIN_RESET    = 8'd24;

  // mode codes seen on the result channel
  localparam logic [MODE_W-1:0] MODE_CHECK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RAISE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_VENT  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_HOLD  = 2'd3;

  // register index decoded from paddr[2]
  localparam logic REG_TARGET_PRESS = 1'b0;
  localparam logic REG_PROP_GAIN    = 1'b1;

  typedef enum logic [3:0] {
    ST_CHECK = 4'b0001,
    ST_RAISE = 4'b0010,
    ST_VENT  = 4'b0100,
    ST_HOLD  = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic               low_pending;
    mode_t              mode;
    logic [PRESS_W-1:0] last_cmp;
  } ctrl_state_t;

  function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
    logic [MODE_W-1:0] c;
    case (m)
      ST_CHECK: c = MODE_CHECK;
      ST_RAISE: c = MODE_RAISE;
      ST_VENT:  c = MODE_VENT;
      ST_HOLD:  c = MODE_HOLD;
      default:  c = MODE_CHECK;
    endcase
    return c;
  endfunction

endpackage

@@ sv/ppbc_if.sv @@
// ----------------------------------------------------------------------------
// ppbc_if
// Valid/ready channels for pressure samples and compare results.
// ----------------------------------------------------------------------------
interface ppbc_in_if;
  logic                         valid;
  logic                         ready;
  logic [ppbc_pkg::PRESS_W-1:0] pressure;
  logic                         pump_enable;

  modport source (output valid, output pressure, output pump_enable, input ready);
  modport sink   (input valid, input pressure, input pump_enable, output ready);
endinterface

interface ppbc_out_if;
  logic                         valid;
  logic                         ready;
  logic [ppbc_pkg::PRESS_W-1:0] compare_value;
  logic [ppbc_pkg::MODE_W-1:0]  mode_now;

  modport source (output valid, output compare_value, output mode_now, input ready);
  modport sink   (input valid, input compare_value, input mode_now, output ready);
endinterface

@@ sv/pump_pressure_band_controller_top.sv @@
// ----------------------------------------------------------------------------
// pump_pressure_band_controller_top
// Pressure band controller: one pressure sample in, one PWM compare out.
// ----------------------------------------------------------------------------
//  channel   direction  handshake      payload
//  in_ch     in         valid/ready    pressure[11:0], pump_enable
//  out_ch    out        valid/ready    compare_value[11:0], mode_now[1:0]
//  apb       in         psel/penable   paddr[2:0], pwdata[31:0], prdata[31:0]
//
// One item per cycle sustained while out_ch is not stalled; an accepted item
// passes through the input register, then the result register, before its
// result is offered. The duty/mode feedback loop closes combinationally in
// the step logic, so consecutive items see each other's state.
// rst_n is synchronous; it restores register defaults and the check mode.
// A stalled out_ch holds its item; the input register still fills behind it.
module pump_pressure_band_controller_top (
  input  logic                          clk,
  input  logic                          rst_n,
  ppbc_in_if.sink                       in_ch,
  ppbc_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppbc_pkg::APB_AW-1:0]   paddr,
  input  logic [ppbc_pkg::APB_DW-1:0]   pwdata,
  output logic [ppbc_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  logic [ppbc_pkg::PRESS_W-1:0] target_press_r;
  logic [ppbc_pkg::GAIN_W-1:0]  prop_gain_r;

  logic                         s1_valid_r;
  logic [ppbc_pkg::PRESS_W-1:0] s1_press_r;
  logic                         s1_en_r;
  logic                         s1_go;

  ppbc_pkg::ctrl_state_t        state_r;
  ppbc_pkg::ctrl_state_t        state_nxt;

  logic                         out_valid_r;
  logic [ppbc_pkg::PRESS_W-1:0] out_cmp_r;
  logic [ppbc_pkg::MODE_W-1:0]  out_mode_r;
  logic                         cfg_wr;

  // ---- APB register file ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_press_r <= ppbc_pkg::SET_RESET;
      prop_gain_r    <= ppbc_pkg::GAIN_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        ppbc_pkg::REG_TARGET_PRESS: target_press_r <= pwdata[ppbc_pkg::PRESS_W-1:0];
        ppbc_pkg::REG_PROP_GAIN:    prop_gain_r    <= pwdata[ppbc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      ppbc_pkg::REG_TARGET_PRESS:
        prdata = {{(ppbc_pkg::APB_DW-ppbc_pkg::PRESS_W){1'b0}}, target_press_r};
      ppbc_pkg::REG_PROP_GAIN:
        prdata = {{(ppbc_pkg::APB_DW-ppbc_pkg::GAIN_W){1'b0}}, prop_gain_r};
      default:
        prdata = '0;
    endcase
  end

  // ---- input register ----
  assign s1_go       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_press_r <= in_ch.pressure;
      s1_en_r    <= in_ch.pump_enable;
    end
  end

  // ---- step logic and controller state ----
  ppbc_step u_step (
    .cur          (state_r),
    .pressure     (s1_press_r),
    .pump_enable  (s1_en_r),
    .target_press (target_press_r),
    .prop_gain    (prop_gain_r),
    .nxt          (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.duty        <= '0;
      state_r.low_pending <= 1'b1;
      state_r.mode        <= ppbc_pkg::ST_CHECK;
      state_r.last_cmp    <= '0;
    end else if (s1_go) begin
      state_r <= state_nxt;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_cmp_r  <= state_nxt.last_cmp;
      out_mode_r <= ppbc_pkg::mode_code(state_nxt.mode);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.compare_value = out_cmp_r;
  assign out_ch.mode_now      = out_mode_r;

endmodule

@@ sv/ppbc_step.sv @@
// ----------------------------------------------------------------------------
// ppbc_step
// Next-state logic for one sample: duty update, band tests, mode change.
// ----------------------------------------------------------------------------
module ppbc_step (
  input  ppbc_pkg::ctrl_state_t         cur,
  input  logic [ppbc_pkg::PRESS_W-1:0]  pressure,
  input  logic                          pump_enable,
  input  logic [ppbc_pkg::PRESS_W-1:0]  target_press,
  input  logic [ppbc_pkg::GAIN_W-1:0]   prop_gain,
  output ppbc_pkg::ctrl_state_t         nxt
);

  logic signed [13:0]            err;
  logic signed [22:0]            prod;
  logic signed [23:0]            sum;
  logic [14:0]                   quo;
  logic [ppbc_pkg::DUTY_W-1:0]   duty_upd;
  logic [13:0]                   p14;
  logic [13:0]                   s14;
  logic                          is_low;
  logic                          raise_ok;
  logic                          above;
  logic                          in_band;
  logic                          lp_v;

  // duty += gain * (set + 16 - p) / 256, clamped to 0..DUTY_MAX
  always_comb begin
    err  = $signed({2'b00, target_press}) + 14'sd16 - $signed({2'b00, pressure});
    prod = $signed({1'b0, prop_gain}) * err;
    sum  = $signed({4'b0000, cur.duty, 8'h00}) + $signed({prod[22], prod});
    quo  = sum[22:8];
    if (sum[23]) begin
      duty_upd = '0;
    end else if (quo > {3'b000, ppbc_pkg::DUTY_MAX}) begin
      duty_upd = ppbc_pkg::DUTY_MAX;
    end else begin
      duty_upd = quo[ppbc_pkg::DUTY_W-1:0];
    end
  end

  // thresholds on widened unsigned values, so set-32 never underflows
  assign p14      = {2'b00, pressure};
  assign s14      = {2'b00, target_press};
  assign is_low   = (p14 + 14'd32) <= s14;
  assign raise_ok = p14 <= (s14 + 14'd16);
  assign above    = p14 > (s14 + 14'd32);
  assign in_band  = ((p14 + 14'd32) >= s14) && !above;
  assign lp_v     = cur.low_pending | is_low;

  always_comb begin
    nxt = cur;
    case (cur.mode)
      ppbc_pkg::ST_CHECK: begin
        if (!pump_enable) begin
          nxt.last_cmp = '0;
        end else if (lp_v && raise_ok) begin
          nxt.duty        = ppbc_pkg::RAISE_PRELOAD;
          nxt.low_pending = 1'b1;
          nxt.mode        = ppbc_pkg::ST_RAISE;
        end else begin
          nxt.duty        = lp_v ? ppbc_pkg::RAISE_PRELOAD : duty_upd;
          nxt.low_pending = 1'b0;
          if (above) begin
            nxt.mode = ppbc_pkg::ST_VENT;
          end else if (in_band) begin
            nxt.mode = ppbc_pkg::ST_HOLD;
          end
        end
      end
      ppbc_pkg::ST_RAISE: begin
        nxt.duty     = duty_upd;
        nxt.last_cmp = duty_upd;
        if (!raise_ok) begin
          nxt.low_pending = 1'b0;
          nxt.mode        = above ? ppbc_pkg::ST_VENT : ppbc_pkg::ST_HOLD;
        end
      end
      ppbc_pkg::ST_VENT: begin
        nxt.duty     = duty_upd;
        nxt.last_cmp = '0;
        if (above) begin
          nxt.mode = ppbc_pkg::ST_VENT;
        end else if (in_band) begin
          nxt.mode = ppbc_pkg::ST_HOLD;
        end else begin
          nxt.mode = ppbc_pkg::ST_CHECK;
        end
      end
      ppbc_pkg::ST_HOLD: begin
        nxt.duty     = '0;
        nxt.last_cmp = '0;
        nxt.mode     = in_band ? ppbc_pkg::ST_HOLD : ppbc_pkg::ST_CHECK;
      end
      default: begin
        nxt.mode = ppbc_pkg::ST_CHECK;
      end
    endcase
  end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pump pressure band controller. Pressure samples
// go in over a valid/ready channel with random gaps, and compare results are
// taken with random stalls, in the directed walk and even phases only. Each
// result is checked against an in-bench model of the duty accumulator and
// the check/raise/vent/hold modes. Registers change between phases over APB.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LIMIT      = 400000;
  localparam int PHASES     = 6;
  localparam int PHASE_LEN  = 75;
  localparam int DIR_LEN    = 24;

  // directed walk at the reset set point (976): every mode edge and threshold
  localparam int DIR_P[DIR_LEN] = '{4095, 0, 0, 944, 960, 4000, 4095, 976, 1008, 1009,
                                    990, 2000, 1009, 943, 943, 992, 993, 944, 943, 1008,
                                    0, 0, 0, 4095};
  localparam bit DIR_EN[DIR_LEN] = '{1, 1, 0, 1, 1, 1, 1, 1, 1, 1,
                                     1, 0, 1, 0, 1, 1, 1, 1, 1, 1,
                                     1, 1, 1, 1};

  typedef struct packed {
    logic [ppbc_pkg::PRESS_W-1:0] pressure;
    logic                         pump_enable;
  } pump_sample_t;

  typedef struct packed {
    logic [ppbc_pkg::DUTY_W-1:0] cmp;
    logic [ppbc_pkg::MODE_W-1:0] mode;
  } pwm_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ppbc_in_if  in_ch ();
  ppbc_out_if out_ch ();

  logic                        psel, penable, pwrite, pready;
  logic [ppbc_pkg::APB_AW-1:0] paddr;
  logic [ppbc_pkg::APB_DW-1:0] pwdata, prdata;

  pump_pressure_band_controller_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // controller model state
  logic [ppbc_pkg::PRESS_W-1:0] set_p;
  logic [ppbc_pkg::GAIN_W-1:0]  gain;
  logic [ppbc_pkg::DUTY_W-1:0]  duty;
  logic                         low_pend;
  logic [ppbc_pkg::MODE_W-1:0]  mode;
  logic [ppbc_pkg::DUTY_W-1:0]  last_cmp;

  pump_sample_t sample_q[$];
  pwm_result_t  pwm_q[$];
  pump_sample_t cur_sample;

  int  n_queued = 0;
  int  n_accepted = 0;
  int  n_results = 0;
  int  n_errors = 0;
  int  cycles = 0;
  int  send_gap = 0;
  int  recv_stall = 0;
  int  mode_hits[4] = '{0, 0, 0, 0};
  bit  idle_on = 1'b1;

  function automatic bit in_band(input int p);
    return p >= int'(set_p) - 32 && p <= int'(set_p) + 32;
  endfunction

  // duty += gain*(set+16-p)/256, floor at 0, clamp at DUTY_MAX
  function automatic void adjust_duty(input int p);
    int sum;
    sum = int'(duty) * 256 + int'(gain) * (int'(set_p) + 16 - p);
    if (sum < 0) duty = '0;
    else if (sum / 256 > int'(ppbc_pkg::DUTY_MAX)) duty = ppbc_pkg::DUTY_MAX;
    else duty = ppbc_pkg::DUTY_W'(sum / 256);
  endfunction

  function automatic pwm_result_t predict_pwm(input pump_sample_t smp);
    int                          p, s;
    logic [ppbc_pkg::DUTY_W-1:0] cmp;
    pwm_result_t                 r;
    p = int'(smp.pressure);
    s = int'(set_p);
    cmp = last_cmp;
    case (mode)
      ppbc_pkg::MODE_CHECK: begin
        if (!smp.pump_enable) begin
          cmp = '0;
        end else begin
          adjust_duty(p);
          if (p <= s - 32) low_pend = 1'b1;
          if (low_pend) begin
            duty = ppbc_pkg::RAISE_PRELOAD;
            if (p <= s + 16) mode = ppbc_pkg::MODE_RAISE;
            else low_pend = 1'b0;
          end
          if (mode == ppbc_pkg::MODE_CHECK) begin
            if (p > s + 32) mode = ppbc_pkg::MODE_VENT;
            else if (in_band(p)) mode = ppbc_pkg::MODE_HOLD;
          end
        end
      end
      ppbc_pkg::MODE_RAISE: begin
        adjust_duty(p);
        cmp = duty;
        if (p > s + 16) begin
          low_pend = 1'b0;
          mode = (p > s + 32) ? ppbc_pkg::MODE_VENT : ppbc_pkg::MODE_HOLD;
        end
      end
      ppbc_pkg::MODE_VENT: begin
        adjust_duty(p);
        cmp = '0;
        if (p > s + 32) mode = ppbc_pkg::MODE_VENT;
        else if (in_band(p)) mode = ppbc_pkg::MODE_HOLD;
        else mode = ppbc_pkg::MODE_CHECK;
      end
      default: begin
        duty = '0;
        cmp = '0;
        mode = in_band(p) ? ppbc_pkg::MODE_HOLD : ppbc_pkg::MODE_CHECK;
      end
    endcase
    last_cmp = cmp;
    r.cmp = cmp;
    r.mode = mode;
    return r;
  endfunction

  // sample driver
  always @(posedge clk) begin : sample_drv
    logic nv;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      nv = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        pwm_q.push_back(predict_pwm(cur_sample));
        n_accepted++;
        nv = 1'b0;
        send_gap = idle_on ? $urandom_range(0, 19) : 0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sample_q.size() > 0) begin
          cur_sample = sample_q.pop_front();
          in_ch.pressure    <= cur_sample.pressure;
          in_ch.pump_enable <= cur_sample.pump_enable;
          nv = 1'b1;
        end
      end
      in_ch.valid <= nv;
    end
  end

  // result monitor
  always @(posedge clk) begin : pwm_mon
    pwm_result_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pwm_q.size() == 0) begin
          $error("unexpected item: compare_value=%0d mode_now=%0d",
                 out_ch.compare_value, out_ch.mode_now);
          n_errors++;
        end else begin
          e = pwm_q.pop_front();
          if (out_ch.compare_value !== e.cmp) begin
            $error("compare_value: expected %0d, got %0d", e.cmp, out_ch.compare_value);
            n_errors++;
          end
          if (out_ch.mode_now !== e.mode) begin
            $error("mode_now: expected %0d, got %0d", e.mode, out_ch.mode_now);
            n_errors++;
          end
          mode_hits[e.mode]++;
        end
        n_results++;
        recv_stall = idle_on ? $urandom_range(0, 19) : 0;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_sample(input int p, input bit en);
    pump_sample_t smp;
    smp.pressure = ppbc_pkg::PRESS_W'(p);
    smp.pump_enable = en;
    sample_q.push_back(smp);
    n_queued++;
  endtask

  // hold off until every queued sample has produced its result
  task automatic wait_idle();
    while (n_accepted < n_queued || pwm_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [ppbc_pkg::APB_DW-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      ppbc_pkg::REG_TARGET_PRESS: set_p = val[ppbc_pkg::PRESS_W-1:0];
      ppbc_pkg::REG_PROP_GAIN:    gain  = val[ppbc_pkg::GAIN_W-1:0];
      default: ;
    endcase
  endtask

  initial begin : stim
    int set_tab[PHASES];
    int gain_tab[PHASES];
    int pv, r;
    in_ch.valid = 1'b0;
    in_ch.pressure = '0;
    in_ch.pump_enable = 1'b0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    set_p = ppbc_pkg::SET_RESET;
    gain = ppbc_pkg::GAIN_RESET;
    duty = '0;
    low_pend = 1'b1;
    mode = ppbc_pkg::MODE_CHECK;
    last_cmp = '0;

    set_tab  = '{976, 0, 4095, 20, 2048, $urandom_range(0, 4095)};
    gain_tab = '{24, 255, 0, 255, 1, $urandom_range(0, 255)};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_LEN; i++) push_sample(DIR_P[i], DIR_EN[i]);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      idle_on = (ph % 2 == 0);
      write_reg(ppbc_pkg::REG_TARGET_PRESS, set_tab[ph]);
      write_reg(ppbc_pkg::REG_PROP_GAIN, gain_tab[ph]);
      pv = set_tab[ph];
      // pressure mostly wanders around the set point so the mode loop cycles
      for (int i = 0; i < PHASE_LEN; i++) begin
        r = $urandom_range(0, 99);
        if (r < 15) pv = $urandom_range(0, 4095);
        else if (r < 35) pv = set_tab[ph] + int'($urandom_range(0, 96)) - 48;
        else pv = pv + int'($urandom_range(0, 48)) - 24;
        if (pv < 0) pv = 0;
        if (pv > 4095) pv = 4095;
        push_sample(pv, $urandom_range(0, 9) != 0);
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    $display("%0d samples checked over %0d register settings, with and without idling",
             n_results, PHASES + 1);
    $display("results per mode check/raise/vent/hold: %0d/%0d/%0d/%0d",
             mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
